/* hdl/svn_pkg.sv */
// shared types and constants for the smooth vertex normal engine
package svn_pkg;

	localparam int unsigned MaxVertices = 2048;
	localparam int unsigned MaxFaces    = 4096;
	localparam int unsigned VIdxW       = $clog2(MaxVertices);
	localparam int unsigned FIdxW       = $clog2(MaxFaces);
	localparam int unsigned FCntW       = FIdxW + 1;
	localparam int unsigned CoordW      = 16;
	localparam int unsigned PosW        = 3 * CoordW;
	localparam int unsigned FnW         = 35;
	localparam int unsigned CornerW     = 3 * VIdxW;
	localparam int unsigned FaceW       = CornerW + 3 * FnW;
	localparam int unsigned SumW        = FnW + FCntW;
	localparam int unsigned MagW        = 25;
	localparam int unsigned SqW         = 52;
	localparam int unsigned RootW       = 26;

	typedef enum logic [1:0] {
		OP_LOAD_VERTEX = 2'd0,
		OP_LOAD_FACE   = 2'd1,
		OP_QUERY       = 2'd2,
		OP_CLEAR       = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FACE_RD0,
		ST_FACE_RD1,
		ST_FACE_RD2,
		ST_FACE_WAIT,
		ST_FACE_DIFF,
		ST_FACE_MUL,
		ST_FACE_WR,
		ST_Q_RD,
		ST_Q_ACC,
		ST_N_ABS,
		ST_N_SHIFT,
		ST_N_SQ,
		ST_N_SQRT,
		ST_N_DIV,
		ST_N_DIVNEXT,
		ST_OUT
	} state_t;

	// handshake between the sequencer and the serial divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;

endpackage

/* hdl/smooth_vertex_normal_engine_unit.sv */
// top level: vertex and face stores, sequencer and shared arithmetic
// Each word is handled one at a time and ready is low while it is worked on.
// A face load makes three position reads from the single port vertex ram
// and one multiply per cycle through a shared 17x17 multiplier; a query makes
// one face ram read per cycle over the stored faces, then scaling shifts, three
// squares, a 26 step square root and three 39 step divides in one serial divider.
// A query of a vertex that no face uses skips the scaling and the arithmetic.
// A finished result waits in the output register without blocking new words;
// only a later query that finishes before it is taken holds there.
// No clearing pass is needed after reset.
module smooth_vertex_normal_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [10:0] vtx_idx,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [10:0] corner_a,
	input  logic [10:0] corner_b,
	input  logic [10:0] corner_c,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [12:0] face_uses
);

	localparam int unsigned VW = svn_pkg::VIdxW;
	localparam int unsigned FW = svn_pkg::FIdxW;
	localparam int unsigned CW = svn_pkg::FCntW;
	localparam int unsigned SW = svn_pkg::SumW;
	localparam int unsigned MW = svn_pkg::MagW;
	localparam int unsigned NW = svn_pkg::MagW + 14;

	svn_pkg::state_t state_q, state_d;

	// request registers
	logic [VW-1:0]      vi_q;
	logic [VW-1:0]      ca_q, cb_q, cc_q;
	logic [CW-1:0]      nfaces_q;
	logic [CW-1:0]      fidx_q;
	logic               rd_valid_q;

	// face build registers
	logic signed [15:0] p0_q [3];
	logic signed [15:0] p1_q [3];
	logic signed [15:0] p2_q [3];
	logic signed [16:0] a_q [3];
	logic signed [16:0] b_q [3];
	logic signed [33:0] prod_q;
	logic signed [34:0] fn_q [3];
	logic [2:0]         mstep_q;

	// query registers
	logic signed [SW-1:0] sum_q [3];
	logic [CW-1:0]        uses_q;
	logic [SW-1:0]        mag_q [3];
	logic [MW-1:0]        sm_q [3];
	logic [svn_pkg::SqW-1:0] sq_q;
	logic [1:0]           k_q;
	logic [svn_pkg::SqW-1:0] rv_q, rr_q, rbit_q;
	logic [svn_pkg::RootW-1:0] root_q;
	logic [15:0]          nrm_q [3];
	logic                 zero_q;

	// output register
	logic                 out_valid_q;
	logic                 out_free;

	// vertex ram
	logic                 v_we;
	logic [VW-1:0]        v_addr;
	logic [svn_pkg::PosW-1:0] v_rdata;

	// face ram
	logic                 f_we;
	logic [FW-1:0]        f_addr;
	logic [svn_pkg::FaceW-1:0] f_wdata, f_rdata;

	// divider
	logic                 div_start;
	logic [NW-1:0]        div_quot;
	svn_pkg::div_ctrl_t   div_ctrl;

	logic                 accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == svn_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	svn_ram #(.Width(svn_pkg::PosW), .Depth(svn_pkg::MaxVertices)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.addr  (v_addr),
		.wdata ({pos_x, pos_y, pos_z}),
		.rdata (v_rdata)
	);

	svn_ram #(.Width(svn_pkg::FaceW), .Depth(svn_pkg::MaxFaces)) u_fram (
		.clk   (clk),
		.we    (f_we),
		.addr  (f_addr),
		.wdata (f_wdata),
		.rdata (f_rdata)
	);

	svn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sm_q[k_q] , 14'd0} + NW'(root_q >> 1)),
		.divisor  (root_q),
		.quotient (div_quot),
		.ctrl     (div_ctrl)
	);

	// ram address and write control
	always_comb begin
		v_we = accept && (svn_pkg::op_t'(op) == svn_pkg::OP_LOAD_VERTEX);
		v_addr = vtx_idx;
		case (state_q)
			svn_pkg::ST_FACE_RD0: v_addr = ca_q;
			svn_pkg::ST_FACE_RD1: v_addr = cb_q;
			svn_pkg::ST_FACE_RD2: v_addr = cc_q;
			default: v_addr = vtx_idx;
		endcase
		f_we    = (state_q == svn_pkg::ST_FACE_WR);
		f_addr  = (state_q == svn_pkg::ST_FACE_WR) ? nfaces_q[FW-1:0] : fidx_q[FW-1:0];
		f_wdata = {ca_q, cb_q, cc_q, fn_q[0], fn_q[1], fn_q[2]};
		div_start = (state_q == svn_pkg::ST_N_DIV) && !div_ctrl.busy && !div_ctrl.done;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			svn_pkg::ST_IDLE: begin
				if (accept) begin
					case (svn_pkg::op_t'(op))
						svn_pkg::OP_LOAD_FACE: begin
							if (nfaces_q < CW'(svn_pkg::MaxFaces)) begin
								state_d = svn_pkg::ST_FACE_RD0;
							end
						end
						svn_pkg::OP_QUERY: state_d = svn_pkg::ST_Q_RD;
						default: state_d = svn_pkg::ST_IDLE;
					endcase
				end
			end
			svn_pkg::ST_FACE_RD0:  state_d = svn_pkg::ST_FACE_RD1;
			svn_pkg::ST_FACE_RD1:  state_d = svn_pkg::ST_FACE_RD2;
			svn_pkg::ST_FACE_RD2:  state_d = svn_pkg::ST_FACE_WAIT;
			svn_pkg::ST_FACE_WAIT: state_d = svn_pkg::ST_FACE_DIFF;
			svn_pkg::ST_FACE_DIFF: state_d = svn_pkg::ST_FACE_MUL;
			svn_pkg::ST_FACE_MUL: begin
				if (mstep_q == 3'd6) begin
					state_d = svn_pkg::ST_FACE_WR;
				end
			end
			svn_pkg::ST_FACE_WR: state_d = svn_pkg::ST_IDLE;
			svn_pkg::ST_Q_RD: begin
				if (fidx_q >= nfaces_q) begin
					state_d = svn_pkg::ST_Q_ACC;
				end
			end
			svn_pkg::ST_Q_ACC: begin
				if (!rd_valid_q) begin
					state_d = svn_pkg::ST_N_ABS;
				end
			end
			svn_pkg::ST_N_ABS: begin
				if (uses_q == '0) begin
					state_d = svn_pkg::ST_OUT;
				end else begin
					state_d = svn_pkg::ST_N_SHIFT;
				end
			end
			svn_pkg::ST_N_SHIFT: begin
				if (zero_q) begin
					state_d = svn_pkg::ST_OUT;
				end else if (mag_q[0] < SW'(25'h0800000) && mag_q[1] < SW'(25'h0800000)
						&& mag_q[2] < SW'(25'h0800000)) begin
					state_d = svn_pkg::ST_N_SHIFT;
				end else if (mag_q[0] >= SW'(25'h1000000) || mag_q[1] >= SW'(25'h1000000)
						|| mag_q[2] >= SW'(25'h1000000)) begin
					state_d = svn_pkg::ST_N_SHIFT;
				end else begin
					state_d = svn_pkg::ST_N_SQ;
				end
			end
			svn_pkg::ST_N_SQ: begin
				if (k_q == 2'd2) begin
					state_d = svn_pkg::ST_N_SQRT;
				end
			end
			svn_pkg::ST_N_SQRT: begin
				if (rbit_q == '0) begin
					state_d = svn_pkg::ST_N_DIV;
				end
			end
			svn_pkg::ST_N_DIV: begin
				if (div_ctrl.done) begin
					state_d = svn_pkg::ST_N_DIVNEXT;
				end
			end
			svn_pkg::ST_N_DIVNEXT: begin
				if (k_q == 2'd2) begin
					state_d = svn_pkg::ST_OUT;
				end else begin
					state_d = svn_pkg::ST_N_DIV;
				end
			end
			svn_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = svn_pkg::ST_IDLE;
				end
			end
			default: state_d = svn_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svn_pkg::ST_IDLE;
			nfaces_q    <= '0;
			out_valid_q <= 1'b0;
			rd_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == svn_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && svn_pkg::op_t'(op) == svn_pkg::OP_CLEAR) begin
				nfaces_q <= '0;
			end
			if (state_q == svn_pkg::ST_FACE_WR) begin
				nfaces_q <= nfaces_q + 1'b1;
			end
			rd_valid_q <= (state_q == svn_pkg::ST_Q_RD) && (fidx_q < nfaces_q);
		end
	end

	// fixed sqrt scan starts
	localparam logic [svn_pkg::SqW-1:0] SqrtTop = {2'b01, {(svn_pkg::SqW-2){1'b0}}};

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			svn_pkg::ST_IDLE: begin
				vi_q   <= vtx_idx;
				ca_q   <= corner_a;
				cb_q   <= corner_b;
				cc_q   <= corner_c;
				fidx_q <= '0;
				mstep_q <= '0;
				uses_q <= '0;
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= '0;
				end
			end
			svn_pkg::ST_FACE_RD1: begin
				{p0_q[0], p0_q[1], p0_q[2]} <= v_rdata;
			end
			svn_pkg::ST_FACE_RD2: begin
				{p1_q[0], p1_q[1], p1_q[2]} <= v_rdata;
			end
			svn_pkg::ST_FACE_WAIT: begin
				{p2_q[0], p2_q[1], p2_q[2]} <= v_rdata;
			end
			svn_pkg::ST_FACE_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					a_q[k] <= 17'(p0_q[k]) - 17'(p2_q[k]);
					b_q[k] <= 17'(p2_q[k]) - 17'(p1_q[k]);
				end
			end
			svn_pkg::ST_FACE_MUL: begin
				// shared multiplier: odd steps load a term, even steps from 2 subtract, steps 0 to 5 form a product
				mstep_q <= mstep_q + 1'b1;
				case (mstep_q)
					3'd0: prod_q <= a_q[1] * b_q[2];
					3'd1: begin
						fn_q[0] <= 35'(prod_q);
						prod_q  <= a_q[2] * b_q[1];
					end
					3'd2: begin
						fn_q[0] <= fn_q[0] - 35'(prod_q);
						prod_q  <= a_q[2] * b_q[0];
					end
					3'd3: begin
						fn_q[1] <= 35'(prod_q);
						prod_q  <= a_q[0] * b_q[2];
					end
					3'd4: begin
						fn_q[1] <= fn_q[1] - 35'(prod_q);
						prod_q  <= a_q[0] * b_q[1];
					end
					3'd5: begin
						fn_q[2] <= 35'(prod_q);
						prod_q  <= a_q[1] * b_q[0];
					end
					default: fn_q[2] <= fn_q[2] - 35'(prod_q);
				endcase
			end
			svn_pkg::ST_Q_RD: begin
				if (fidx_q < nfaces_q) begin
					fidx_q <= fidx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase

		// face accumulate, one face per cycle behind the ram read
		if (rd_valid_q) begin
			if (f_rdata[svn_pkg::FaceW-1 -: VW] == vi_q
					|| f_rdata[svn_pkg::FaceW-VW-1 -: VW] == vi_q
					|| f_rdata[svn_pkg::FaceW-2*VW-1 -: VW] == vi_q) begin
				uses_q <= uses_q + 1'b1;
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= sum_q[k] + SW'($signed(f_rdata[(2-k)*svn_pkg::FnW +: svn_pkg::FnW]));
				end
			end
		end

		case (state_q)
			svn_pkg::ST_N_ABS: begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= sum_q[k][SW-1] ? SW'(-sum_q[k]) : SW'(sum_q[k]);
				end
			end
			default: begin
			end
		endcase

		// scaling: one bit shift per cycle
		if (state_q == svn_pkg::ST_N_ABS) begin
			zero_q <= (sum_q[0] == '0) && (sum_q[1] == '0) && (sum_q[2] == '0);
		end
		if (state_q == svn_pkg::ST_N_SHIFT) begin
			if (mag_q[0] >= SW'(25'h1000000) || mag_q[1] >= SW'(25'h1000000)
					|| mag_q[2] >= SW'(25'h1000000)) begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= mag_q[k] >> 1;
				end
			end else if (mag_q[0] < SW'(25'h0800000) && mag_q[1] < SW'(25'h0800000)
					&& mag_q[2] < SW'(25'h0800000)) begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= mag_q[k] << 1;
				end
			end
			k_q <= '0;
			sq_q <= '0;
		end
		if (state_q == svn_pkg::ST_N_ABS || state_q == svn_pkg::ST_N_SHIFT) begin
			for (int k = 0; k < 3; k++) begin
				sm_q[k] <= (mag_q[k] >= SW'(25'h1000000)) ? 25'h1FFFFFF : MW'(mag_q[k]);
			end
		end

		// sum of squares, one square per cycle
		if (state_q == svn_pkg::ST_N_SQ) begin
			sq_q <= sq_q + svn_pkg::SqW'(sm_q[k_q] * sm_q[k_q]);
			k_q  <= k_q + 1'b1;
			rv_q <= sq_q + svn_pkg::SqW'(sm_q[k_q] * sm_q[k_q]);
			rr_q <= '0;
			rbit_q <= SqrtTop;
		end

		// square root, two bits per step
		if (state_q == svn_pkg::ST_N_SQRT) begin
			if (rbit_q != '0) begin
				if (rv_q >= rr_q + rbit_q) begin
					rv_q <= rv_q - (rr_q + rbit_q);
					rr_q <= (rr_q >> 1) + rbit_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				rbit_q <= rbit_q >> 2;
			end
			root_q <= svn_pkg::RootW'(rr_q);
			k_q <= '0;
		end

		// divides through the serial unit
		if (state_q == svn_pkg::ST_N_DIV && div_ctrl.done) begin
			nrm_q[k_q] <= (div_quot > NW'(16384)) ? 16'd16384 : div_quot[15:0];
		end
		if (state_q == svn_pkg::ST_N_DIVNEXT) begin
			k_q <= k_q + 1'b1;
		end

		// result register, loaded once the previous result is taken
		if (state_q == svn_pkg::ST_OUT && out_free) begin
			face_uses <= uses_q;
			if (uses_q == '0 || zero_q) begin
				normal_x <= '0;
				normal_y <= '0;
				normal_z <= '0;
			end else begin
				normal_x <= sum_q[0][SW-1] ? -$signed(nrm_q[0]) : $signed(nrm_q[0]);
				normal_y <= sum_q[1][SW-1] ? -$signed(nrm_q[1]) : $signed(nrm_q[1]);
				normal_z <= sum_q[2][SW-1] ? -$signed(nrm_q[2]) : $signed(nrm_q[2]);
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/svn_ram.sv */
// generic single port ram with registered read
module svn_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hdl/svn_div.sv */
// restoring serial divider, one quotient bit per cycle
module svn_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [svn_pkg::MagW+14-1:0]     dividend,
	input  logic [svn_pkg::RootW-1:0]       divisor,
	output logic [svn_pkg::MagW+14-1:0]     quotient,
	output svn_pkg::div_ctrl_t              ctrl
);

	localparam int unsigned NW = svn_pkg::MagW + 14;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0]                 num_q;
	logic [svn_pkg::RootW:0]       rem_q;
	logic [svn_pkg::RootW-1:0]     den_q;
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [svn_pkg::RootW:0]       trial;
	logic [svn_pkg::RootW+1:0]     diff;

	// one shift and subtract step
	always_comb begin
		trial = {rem_q[svn_pkg::RootW-1:0], num_q[NW-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[svn_pkg::RootW+1]) begin
				rem_q <= diff[svn_pkg::RootW:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quotient   = num_q;
	assign ctrl.start = start;
	assign ctrl.busy  = busy_q;
	assign ctrl.done  = done_q;

endmodule
